// File: rtl/gnsl_pkg.sv
`default_nettype none

package gnsl_pkg;

  // Field widths of one word
  localparam int unsigned CoordW = 12;
  localparam int unsigned LabelW = 6;
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned DistW  = SqW + 1;

  // Command codes of an input word
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // Input word
  typedef struct packed {
    cmd_e              cmd;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [LabelW-1:0] site_label;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [LabelW-1:0] nearest_label;
    logic              no_sites;
  } out_word_t;

  // Token that travels down the chain of site cells
  typedef struct packed {
    cmd_e              cmd;
    logic [CoordW-1:0] qx;
    logic [CoordW-1:0] qy;
    logic [LabelW-1:0] label;
    logic              claimed;     // load already taken by a cell
    logic              best_valid;  // some site seen so far
    logic [DistW-1:0]  best_dist;
    logic [CoordW-1:0] best_x;
    logic [CoordW-1:0] best_y;
    logic [LabelW-1:0] best_label;
  } tok_t;

  // Candidate a cell offers to a query, between its two stages
  typedef struct packed {
    logic              valid;
    logic [SqW-1:0]    sq_x;
    logic [SqW-1:0]    sq_y;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [LabelW-1:0] label;
  } cand_t;

endpackage

`default_nettype wire

// File: rtl/grid_nearest_site_label.sv
`default_nettype none

// Nearest-site labeler: a chain of MAX_SITES cells, each holding one site.
// Every word (clear, load, query) walks the chain in order, two register
// stages per cell, so one word is taken per cycle unless in_ready_o is low;
// a query's result is registered as it leaves the chain. Loads fill the first
// empty cell; a load that finds every cell full is dropped. Each cell squares
// the query's distance to its site and keeps the nearer of its site and the
// best so far (ties go to smaller x, then smaller y, then the earlier load).
// A query with no site loaded returns no_sites=1 and label 0. Clears, loads
// and unused codes give no result. in_ready_o drops only while a result
// waits in the output register and another query has reached the chain end.

module grid_nearest_site_label import gnsl_pkg::*; #(
  parameter int unsigned MAX_SITES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic [MAX_SITES:0]   chain_valid;
  tok_t                 chain_tok [MAX_SITES+1];
  logic [MAX_SITES-1:0] site_vld;
  tok_t                 entry_tok;
  logic                 last_query;
  logic                 adv;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_word_q, out_word_d;

  // Build the entry token from the input word
  always_comb begin
    entry_tok       = '0;
    entry_tok.cmd   = in_word_i.cmd;
    entry_tok.qx    = in_word_i.coord_x;
    entry_tok.qy    = in_word_i.coord_y;
    entry_tok.label = in_word_i.site_label;
  end

  assign chain_valid[0] = in_valid_i;
  assign chain_tok[0]   = entry_tok;

  // Chain of site cells
  for (genvar k = 0; k < MAX_SITES; k++) begin : g_cell
    gnsl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .valid_i    (chain_valid[k]),
      .tok_i      (chain_tok[k]),
      .valid_o    (chain_valid[k+1]),
      .tok_o      (chain_tok[k+1]),
      .site_vld_o (site_vld[k])
    );
  end

  // Stall the chain only when a query at its end cannot enter the output register
  assign last_query = chain_valid[MAX_SITES] && (chain_tok[MAX_SITES].cmd == CMD_QUERY);
  assign adv        = !out_valid_q || out_ready_i || !last_query;
  assign in_ready_o = adv;

  // Output register: hold until taken, load when a query leaves the chain
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    if (last_query && adv) begin
      out_valid_d              = 1'b1;
      out_word_d.no_sites      = !chain_tok[MAX_SITES].best_valid;
      out_word_d.nearest_label = chain_tok[MAX_SITES].best_valid ?
                                 chain_tok[MAX_SITES].best_label : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // Occupied cells form a prefix of the chain once no word is in flight
  a_site_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((chain_valid == '0) && ($past(chain_valid) == '0)) |->
    (((site_vld + MAX_SITES'(1)) & site_vld) == '0))
    else $error("occupied cells are not a prefix");

  // An empty-store result carries label zero
  a_empty_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.no_sites) |-> (out_word_o.nearest_label == '0))
    else $error("empty-store result with nonzero label");
`endif

endmodule

`default_nettype wire

// File: rtl/gnsl_cell.sv
`default_nettype none

module gnsl_cell import gnsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  tok_t tok_i,
  output logic valid_o,
  output tok_t tok_o,
  output logic site_vld_o
);

  logic              site_vld_q, site_vld_d;
  logic [CoordW-1:0] site_x_q, site_x_d;
  logic [CoordW-1:0] site_y_q, site_y_d;
  logic [LabelW-1:0] site_lbl_q, site_lbl_d;

  logic              a_valid_q;
  tok_t              a_tok_q, a_tok_d;
  cand_t             a_cand_q, a_cand_d;
  logic              b_valid_q;
  tok_t              b_tok_q, b_tok_d;

  logic              take_load;
  logic [CoordW-1:0] dx, dy;
  logic [DistW-1:0]  cand_dist;
  logic              cand_wins;

  // Claim a load word when this cell is empty and no cell upstream took it
  assign take_load = valid_i && (tok_i.cmd == CMD_LOAD) && !tok_i.claimed && !site_vld_q;

  // Update the held site on clear and load
  always_comb begin
    site_vld_d = site_vld_q;
    site_x_d   = site_x_q;
    site_y_d   = site_y_q;
    site_lbl_d = site_lbl_q;
    if (adv_i && valid_i) begin
      if (tok_i.cmd == CMD_CLEAR) begin
        site_vld_d = 1'b0;
      end else if (take_load) begin
        site_vld_d = 1'b1;
        site_x_d   = tok_i.qx;
        site_y_d   = tok_i.qy;
        site_lbl_d = tok_i.label;
      end
    end
  end

  // Stage A: square the axis distances to the held site
  always_comb begin
    dx = (tok_i.qx >= site_x_q) ? (tok_i.qx - site_x_q) : (site_x_q - tok_i.qx);
    dy = (tok_i.qy >= site_y_q) ? (tok_i.qy - site_y_q) : (site_y_q - tok_i.qy);
    a_tok_d = tok_i;
    if (take_load) begin
      a_tok_d.claimed = 1'b1;
    end
    a_cand_d.valid = site_vld_q && (tok_i.cmd == CMD_QUERY);
    a_cand_d.sq_x  = SqW'(dx) * SqW'(dx);
    a_cand_d.sq_y  = SqW'(dy) * SqW'(dy);
    a_cand_d.x     = site_x_q;
    a_cand_d.y     = site_y_q;
    a_cand_d.label = site_lbl_q;
  end

  // Stage B: sum and replace the running best only on a strict win
  always_comb begin
    cand_dist = DistW'(a_cand_q.sq_x) + DistW'(a_cand_q.sq_y);
    cand_wins = a_cand_q.valid &&
                (!a_tok_q.best_valid ||
                 (cand_dist < a_tok_q.best_dist) ||
                 ((cand_dist == a_tok_q.best_dist) &&
                  ((a_cand_q.x < a_tok_q.best_x) ||
                   ((a_cand_q.x == a_tok_q.best_x) && (a_cand_q.y < a_tok_q.best_y)))));
    b_tok_d = a_tok_q;
    if (cand_wins) begin
      b_tok_d.best_valid = 1'b1;
      b_tok_d.best_dist  = cand_dist;
      b_tok_d.best_x     = a_cand_q.x;
      b_tok_d.best_y     = a_cand_q.y;
      b_tok_d.best_label = a_cand_q.label;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_vld_q <= 1'b0;
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
    end else begin
      site_vld_q <= site_vld_d;
      if (adv_i) begin
        a_valid_q <= valid_i;
        b_valid_q <= a_valid_q;
      end
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    site_x_q   <= site_x_d;
    site_y_q   <= site_y_d;
    site_lbl_q <= site_lbl_d;
    if (adv_i) begin
      a_tok_q  <= a_tok_d;
      a_cand_q <= a_cand_d;
      b_tok_q  <= b_tok_d;
    end
  end

  assign valid_o    = b_valid_q;
  assign tok_o      = b_tok_q;
  assign site_vld_o = site_vld_q;

endmodule

`default_nettype wire
